>>> rtl/core/uue_pkg.sv
package uue_pkg;

  // Default line length in bytes
  localparam int unsigned LINE_BYTES = 45;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic [7:0]  CHAR_NL        = 8'h0A;
  localparam logic [7:0]  CHAR_BQ        = 8'h60;
  localparam logic [7:0]  CHAR_OFFSET    = 8'h20;
  localparam logic [31:0] TEXT_ZERO_LINE = 32'h0000_0A60;  // "`\n"
  localparam logic [31:0] TEXT_END       = 32'h0A64_6E65;  // "end\n"

  localparam logic [2:0] CNT_ONE  = 3'd1;
  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  typedef enum logic [2:0] {
    SEL_LEN,
    SEL_GRP,
    SEL_NL,
    SEL_ZL,
    SEL_END
  } out_sel_e;

  typedef struct packed {
    logic     wr;
    logic     clr_fill;
    logic     ptr_clr;
    logic     ptr_adv;
    logic     rd_en;
    logic [1:0] rd_sub;
    logic     cap_en;
    logic [1:0] cap_sub;
    logic     out_load;
    out_sel_e sel;
    logic     last;
  } uue_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_last;
    logic grp_more;
    logic out_free;
  } uue_sts_t;

  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] r;
    if (v == 6'd0) begin
      r = CHAR_BQ;
    end else begin
      r = {2'b00, v} + CHAR_OFFSET;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/uue_ctrl.sv
module uue_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            command_i,
  output logic            in_stall_o,
  input  uue_pkg::uue_sts_t sts_i,
  output uue_pkg::uue_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_RD,
    ST_GRP,
    ST_NL,
    ST_ZL,
    ST_END
  } state_e;

  state_e state_q, state_d;
  logic   eos_q, eos_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    eos_d   = eos_q;
    cmd_o   = '0;
    cmd_o.sel = uue_pkg::SEL_LEN;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == uue_pkg::CMD_EOS) begin
            eos_d   = 1'b1;
            state_d = sts_i.fill_zero ? ST_ZL : ST_LEN;
          end else begin
            eos_d    = 1'b0;
            cmd_o.wr = 1'b1;
            if (sts_i.fill_last) begin
              state_d = ST_LEN;
            end
          end
        end
      end
      ST_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.sel      = uue_pkg::SEL_LEN;
          cmd_o.ptr_clr  = 1'b1;
          state_d        = ST_RA;
        end
      end
      ST_RA: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sub = 2'd0;
        state_d      = ST_RB;
      end
      ST_RB: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sub = 2'd0;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sub  = 2'd1;
        state_d       = ST_RC;
      end
      ST_RC: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sub = 2'd1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sub  = 2'd2;
        state_d       = ST_RD;
      end
      ST_RD: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sub = 2'd2;
        state_d       = ST_GRP;
      end
      ST_GRP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.sel      = uue_pkg::SEL_GRP;
          cmd_o.ptr_adv  = 1'b1;
          state_d        = sts_i.grp_more ? ST_RA : ST_NL;
        end
      end
      ST_NL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.sel      = uue_pkg::SEL_NL;
          cmd_o.last     = !eos_q;
          cmd_o.clr_fill = 1'b1;
          state_d        = eos_q ? ST_ZL : ST_IDLE;
        end
      end
      ST_ZL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.sel      = uue_pkg::SEL_ZL;
          state_d        = ST_END;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.sel      = uue_pkg::SEL_END;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eos_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eos_q   <= eos_d;
    end
  end

endmodule

>>> rtl/core/uue_dpath.sv
module uue_dpath #(
  parameter int unsigned LineBytes = uue_pkg::LINE_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  uue_pkg::uue_cmd_t cmd_i,
  output uue_pkg::uue_sts_t sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [31:0]       text_o,
  output logic [2:0]        char_count_o,
  output logic              last_of_run_o
);

  localparam int unsigned AddrW      = $clog2(LineBytes);
  localparam int unsigned FillW      = $clog2(LineBytes + 1);
  localparam int unsigned StoreDepth = 2 ** AddrW;

  logic [7:0] mem [StoreDepth];

  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] ptr_q;
  logic [FillW:0]   rd_ext;
  logic [FillW:0]   grp_next;
  logic [7:0]       rdata_q;
  logic             rok_q;
  logic [7:0]       b0_q, b1_q, b2_q;
  logic [7:0]       cap_byte;
  logic             out_valid_q;
  logic [31:0]      text_q, text_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             last_q;

  assign rd_ext   = {1'b0, ptr_q} + (FillW + 1)'(cmd_i.rd_sub);
  assign grp_next = {1'b0, ptr_q} + (FillW + 1)'(3);

  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.fill_last = (fill_q == FillW'(LineBytes - 1));
  assign sts_o.grp_more  = (grp_next < {1'b0, fill_q});
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[fill_q[AddrW-1:0]] <= data_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_ext[AddrW-1:0]];
      rok_q   <= (rd_ext < {1'b0, fill_q});
    end
  end

  // bytes past the end of the line read as zero padding
  assign cap_byte = rok_q ? rdata_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      case (cmd_i.cap_sub)
        2'd0:    b0_q <= cap_byte;
        2'd1:    b1_q <= cap_byte;
        default: b2_q <= cap_byte;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
    end else begin
      if (cmd_i.clr_fill) begin
        fill_q <= '0;
      end else if (cmd_i.wr) begin
        fill_q <= fill_q + FillW'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_adv) begin
        ptr_q <= grp_next[FillW-1:0];
      end
    end
  end

  always_comb begin
    text_d = '0;
    cnt_d  = uue_pkg::CNT_ONE;
    unique case (cmd_i.sel)
      uue_pkg::SEL_LEN: begin
        text_d = {24'h0, uue_pkg::enc6(6'(fill_q))};
        cnt_d  = uue_pkg::CNT_ONE;
      end
      uue_pkg::SEL_GRP: begin
        text_d = {uue_pkg::enc6(b2_q[5:0]),
                  uue_pkg::enc6({b1_q[3:0], b2_q[7:6]}),
                  uue_pkg::enc6({b0_q[1:0], b1_q[7:4]}),
                  uue_pkg::enc6(b0_q[7:2])};
        cnt_d  = uue_pkg::CNT_FOUR;
      end
      uue_pkg::SEL_NL: begin
        text_d = {24'h0, uue_pkg::CHAR_NL};
        cnt_d  = uue_pkg::CNT_ONE;
      end
      uue_pkg::SEL_ZL: begin
        text_d = uue_pkg::TEXT_ZERO_LINE;
        cnt_d  = uue_pkg::CNT_TWO;
      end
      uue_pkg::SEL_END: begin
        text_d = uue_pkg::TEXT_END;
        cnt_d  = uue_pkg::CNT_FOUR;
      end
      default: begin
        text_d = '0;
        cnt_d  = uue_pkg::CNT_ONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      text_q <= text_d;
      cnt_q  <= cnt_d;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign text_o        = text_q;
  assign char_count_o  = cnt_q;
  assign last_of_run_o = last_q;

endmodule

>>> rtl/core/uuencode_line_encoder_unit.sv
// uuencode line encoder.
// Input channel (in_valid_i / in_stall_o): one beat is a data byte
// (command_i = data) or an end-of-stream flush (command_i = eos).
// Output channel (out_valid_o / out_stall_i): one beat carries up to four
// ASCII characters in text_o, first character in bits 7..0, with their
// number in char_count_o; last_of_run_o marks the final beat of a run.
// Throughput: data bytes that do not complete a line stream at one per
// cycle. The byte that completes a line, or a flush, stalls the input
// until the whole run has been handed to the output register. After the
// accept the sequencer loads the length beat once the output register is
// free; each 3-byte group then takes three registered reads of the line
// store, the last capture and the load.
// A flush adds two beats ("`\n" and "end\n") after any partial line.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits; nothing is dropped.
// Reset clears the fill count, the sequencer and the output valid; the
// line store itself is not cleared since entries past the fill count are masked to zero.
module uuencode_line_encoder_unit #(
  parameter int unsigned LineBytes = uue_pkg::LINE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] text_o,
  output logic [2:0]  char_count_o,
  output logic        last_of_run_o
);

  uue_pkg::uue_cmd_t cmd;
  uue_pkg::uue_sts_t sts;

  // sequencer: accepts beats, walks the line group by group
  uue_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // line store, group assembly, character encode and output register
  uue_dpath #(
    .LineBytes (LineBytes)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .text_o        (text_o),
    .char_count_o  (char_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> tb/uue_checker.sv
`timescale 1ns / 1ps

module uue_checker #(
  parameter int unsigned LineLen = uue_pkg::LINE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] text_i,
  input  logic [2:0]  char_count_i,
  input  logic        last_of_run_i,
  input  logic        final_check_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  typedef struct packed {
    logic [31:0] text;
    logic [2:0]  count;
    logic        last;
  } text_beat_t;

  text_beat_t  text_due[$];
  logic [7:0]  line_buf [LineLen];
  int unsigned line_fill = 0;
  int unsigned mismatches = 0;
  int unsigned due_count = 0;

  function automatic logic [7:0] uu_char(input logic [5:0] v);
    return (v == 6'd0) ? uue_pkg::CHAR_BQ : uue_pkg::CHAR_OFFSET + {2'b00, v};
  endfunction

  function void due_beat(input logic [31:0] t, input logic [2:0] c);
    text_beat_t b;
    b.text  = t;
    b.count = c;
    b.last  = 1'b0;
    text_due.push_back(b);
  endfunction

  // length char, 4-char groups (short group zero padded), newline
  function void due_line(input int unsigned n);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [31:0] grp;
    due_beat({24'h0, uu_char(n[5:0])}, uue_pkg::CNT_ONE);
    for (int unsigned i = 0; i < n; i += 3) begin
      b0  = line_buf[i];
      b1  = (i + 1 < n) ? line_buf[i+1] : 8'h00;
      b2  = (i + 2 < n) ? line_buf[i+2] : 8'h00;
      grp = {uu_char(b2[5:0]), uu_char({b1[3:0], b2[7:6]}),
             uu_char({b0[1:0], b1[7:4]}), uu_char(b0[7:2])};
      due_beat(grp, uue_pkg::CNT_FOUR);
    end
    due_beat({24'h0, uue_pkg::CHAR_NL}, uue_pkg::CNT_ONE);
  endfunction

  function void encode_input(input logic cmd, input logic [7:0] data);
    int unsigned prior_size;
    text_beat_t  tail;
    prior_size = text_due.size();
    if (cmd == uue_pkg::CMD_DATA) begin
      line_buf[line_fill] = data;
      line_fill++;
      if (line_fill == LineLen) begin
        due_line(line_fill);
        line_fill = 0;
      end
    end else begin
      if (line_fill != 0) due_line(line_fill);
      line_fill = 0;
      due_beat(uue_pkg::TEXT_ZERO_LINE, uue_pkg::CNT_TWO);
      due_beat(uue_pkg::TEXT_END, uue_pkg::CNT_FOUR);
    end
    if (text_due.size() > prior_size) begin
      tail      = text_due.pop_back();
      tail.last = 1'b1;
      text_due.push_back(tail);
    end
  endfunction

  always @(posedge clk_i) begin : watch
    text_beat_t want;
    if (rst_ni) begin
      // check before predicting: a result never leaves on its own input's beat
      if (out_valid_i && !out_stall_i) begin
        if (text_due.size() == 0) begin
          $error("unexpected text beat: text %h count %0d last %0b",
                 text_i, char_count_i, last_of_run_i);
          mismatches++;
        end else begin
          want = text_due.pop_front();
          if (text_i !== want.text) begin
            $error("text: expected %h, actual %h", want.text, text_i);
            mismatches++;
          end
          if (char_count_i !== want.count) begin
            $error("char_count: expected %0d, actual %0d", want.count, char_count_i);
            mismatches++;
          end
          if (last_of_run_i !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) encode_input(command_i, data_byte_i);
      due_count <= text_due.size();
    end
  end

  assign pending_o    = due_count;
  assign fail_count_o = mismatches + (final_check_i ? due_count : 0);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LineLen    = uue_pkg::LINE_BYTES;
  localparam int unsigned ItemTarget = 260;
  // run guard limit; keep a wide margin
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAtItem = 60;
  localparam int unsigned CalmFrom   = 120;
  localparam int unsigned CalmTo     = 180;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        command_i    = uue_pkg::CMD_DATA;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] text_o;
  logic [2:0]  char_count_o;
  logic        last_of_run_o;

  logic        final_check  = 1'b0;
  int unsigned beats_pending;
  int unsigned fail_count;

  int unsigned sent       = 0;      // accepted input beats
  int unsigned cycle_cnt  = 0;
  logic        calm       = 1'b0;   // no idling on either side while set
  logic        hold_req   = 1'b0;   // ask receiver for its long hold-off
  int unsigned hold_cnt   = 0;
  int unsigned seg_len;

  uuencode_line_encoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .text_o        (text_o),
    .char_count_o  (char_count_o),
    .last_of_run_o (last_of_run_o)
  );

  // Watches both channels, predicts the text beats and compares them.
  uue_checker #(
    .LineLen (LineLen)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .command_i     (command_i),
    .data_byte_i   (data_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .text_i        (text_o),
    .char_count_i  (char_count_o),
    .last_of_run_i (last_of_run_o),
    .final_check_i (final_check),
    .pending_o     (beats_pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake ends here.
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // Sender idling: about one cycle in five, none inside the calm window.
  // Valid is lowered here between beats, never in the same step it is raised.
  task automatic idle_gap();
    calm = (sent >= CalmFrom) && (sent < CalmTo);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offer one beat and hold it steady until the block takes it.
  // in_stall_o is read right after the edge, so it is the value the edge saw.
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    idle_gap();
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    if (sent == HoldAtItem) hold_req = 1'b1;
  endtask

  // Receiver: random stalls, plus one long hold-off counted here so the
  // sender keeps offering and the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_cnt < HoldCycles) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: flush on empty buffer, partial groups of one and two bytes,
    // a full group, a group plus one, all-zero and all-one bytes, and a
    // flush right after a flush.
    send_beat(uue_pkg::CMD_EOS,  8'hFF);
    send_beat(uue_pkg::CMD_DATA, 8'h00);
    send_beat(uue_pkg::CMD_EOS,  8'h00);
    send_beat(uue_pkg::CMD_DATA, 8'hFF);
    send_beat(uue_pkg::CMD_DATA, 8'hFF);
    send_beat(uue_pkg::CMD_EOS,  8'h5A);
    send_beat(uue_pkg::CMD_DATA, 8'h00);
    send_beat(uue_pkg::CMD_DATA, 8'hFF);
    send_beat(uue_pkg::CMD_DATA, 8'h80);
    send_beat(uue_pkg::CMD_EOS,  8'hA5);
    send_beat(uue_pkg::CMD_DATA, 8'h01);
    send_beat(uue_pkg::CMD_DATA, 8'h7F);
    send_beat(uue_pkg::CMD_DATA, 8'hFE);
    send_beat(uue_pkg::CMD_DATA, 8'hAA);
    send_beat(uue_pkg::CMD_EOS,  8'h00);
    send_beat(uue_pkg::CMD_EOS,  8'hFF);

    // Random: runs of data bytes closed by a flush. Some runs are exact
    // multiples of a line so the flush lands on an empty buffer, some span
    // one or more full lines, most stay inside a single partial line.
    while (sent < ItemTarget) begin
      case ($urandom_range(0, 7))
        0:       seg_len = LineLen * $urandom_range(1, 2);
        1, 2:    seg_len = $urandom_range(LineLen, 2 * LineLen - 1);
        default: seg_len = $urandom_range(0, LineLen - 1);
      endcase
      // last run is cut so the total lands on the target
      if (sent + seg_len >= ItemTarget) seg_len = ItemTarget - sent - 1;
      repeat (seg_len) send_beat(uue_pkg::CMD_DATA, 8'($urandom));
      send_beat(uue_pkg::CMD_EOS, 8'($urandom));
    end

    in_valid_i <= 1'b0;
    // wait so the checker has taken the last beat into account
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    // let any straggling beat show up
    repeat (200) @(posedge clk_i);
    final_check <= 1'b1;
    @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
